// File: src/dib_pkg.sv
// shared types and constants for the 24-input debounce filter
// no dependencies
package dib_pkg;

  localparam int unsigned NUM_BITS = 24;
  localparam logic [7:0] IDLE_MARK = 8'hFF;
  localparam logic [7:0] FILTER_RESET = 8'd10;

  typedef logic [NUM_BITS-1:0] bits_t;
  typedef logic [7:0] count_t;

  // result of one filter pass, handed to the output register
  typedef struct packed {
    logic  emit;
    logic  changed;
    bits_t state;
  } result_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

// File: src/digital_input_debounce_24.sv
// 24-input time-based debounce filter, top level; uses dib_pkg, dib_map, dib_filter
// path: input register, combinational filter pass, then output register
// throughput: one input beat per cycle while no stalled result blocks it, set by the
// combinational filter pass between the input register and the output register
// reset: filtered and staging bits clear, all counters idle, timestamp 0,
// filter time 10 ms; both pipeline registers empty
module digital_input_debounce_24 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] port_a_raw,
  input  logic [15:0] port_b_raw,
  input  logic [31:0] now_ms,
  input  logic        force_send,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] filtered_state,
  output logic        changed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import dib_pkg::*;

  bits_t       sample;
  logic        s1_valid;
  bits_t       s1_sample;
  logic [31:0] s1_now;
  logic        s1_force;
  logic        advance;
  result_t     res;

  dib_map u_map (
    .port_a_raw (port_a_raw),
    .port_b_raw (port_b_raw),
    .sample     (sample)
  );

  // the filter pass runs when the output register can take its result
  assign advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample;
      s1_now <= now_ms;
      s1_force <= force_send;
    end
  end

  dib_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .advance    (advance),
    .sample     (s1_sample),
    .now_ms     (s1_now),
    .force_send (s1_force),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      filtered_state <= res.state;
      changed <= res.changed;
    end
  end

  // a stall upstream only happens with a beat held behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a forced beat always yields a result
  a_force_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_force) |=> out_valid)
    else $error("forced beat produced no result");

  // a taken result with nothing behind it leaves the output empty
  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !advance) |=> !out_valid)
    else $error("result repeated");

endmodule

// File: src/dib_map.sv
// maps the two raw expander words to 24 active-high input bits
// depends on dib_pkg
module dib_map (
  input  logic [15:0]   port_a_raw,
  input  logic [15:0]   port_b_raw,
  output dib_pkg::bits_t sample
);
  import dib_pkg::*;

  logic [7:0] t;
  logic [7:0] t_rot;

  always_comb begin
    t = flip8(port_a_raw[15:8]);
    // low nibble moves up one place, bit 4 wraps to bit 0
    t_rot = {t[7:5], t[3:0], t[4]};
    sample = {~flip8(port_b_raw[15:8]), ~t_rot, ~flip8(port_a_raw[7:0])};
  end

endmodule

// File: src/dib_filter.sv
// debounce state: filtered and staging bits, per-bit elapsed counters,
// last timestamp and filter time register; depends on dib_pkg
module dib_filter (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr,
  input  logic [7:0]       cfg_data,
  input  logic             advance,
  input  dib_pkg::bits_t   sample,
  input  logic [31:0]      now_ms,
  input  logic             force_send,
  output dib_pkg::result_t res
);
  import dib_pkg::*;

  logic [7:0]  filter_time;
  bits_t       filtered;
  bits_t       staging;
  count_t      elapsed_cnt [NUM_BITS];
  logic [31:0] last_time;

  bits_t       filtered_next;
  count_t      elapsed_cnt_next [NUM_BITS];
  logic [31:0] elapsed;
  logic        big;
  logic [8:0]  sum [NUM_BITS];
  bits_t       accepted;

  always_comb begin
    elapsed = now_ms - last_time;
    big = elapsed >= {24'd0, filter_time};
    filtered_next = filtered;
    accepted = '0;
    for (int k = 0; k < NUM_BITS; k++) begin
      sum[k] = {1'b0, elapsed[7:0]} + {1'b0, elapsed_cnt[k]};
      elapsed_cnt_next[k] = elapsed_cnt[k];
      if (sample[k] != staging[k]) begin
        // new level starts timing only if it differs from the filtered bit
        elapsed_cnt_next[k] = (filtered[k] == sample[k]) ? IDLE_MARK : 8'd0;
      end else if (elapsed_cnt[k] != IDLE_MARK) begin
        if (big || sum[k] > {1'b0, filter_time}) begin
          elapsed_cnt_next[k] = IDLE_MARK;
          filtered_next[k] = sample[k];
          accepted[k] = 1'b1;
        end else begin
          elapsed_cnt_next[k] = sum[k][7:0];
        end
      end
    end
    res.changed = |accepted;
    res.emit = force_send || res.changed;
    res.state = filtered_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_time <= FILTER_RESET;
    end else if (cfg_wr) begin
      filter_time <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered <= '0;
      staging <= '0;
      last_time <= '0;
      for (int k = 0; k < NUM_BITS; k++) begin
        elapsed_cnt[k] <= IDLE_MARK;
      end
    end else if (advance) begin
      filtered <= filtered_next;
      staging <= sample;
      last_time <= now_ms;
      for (int k = 0; k < NUM_BITS; k++) begin
        elapsed_cnt[k] <= elapsed_cnt_next[k];
      end
    end
  end

endmodule
